// File: hdl/rlbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rlbc_pkg
// Shared types and constants of the reference counted lru buffer cache:
// command and status codes, request/response words, slot row layout and the
// controller/datapath interface.
// ============================================================================
package rlbc_pkg;

    // field widths fixed by the interface
    localparam int SLOT_W = 5;
    localparam int COUNT_W = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // command codes
    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_COUNT  = 2'd2
    } t_status;

    // request word
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  slot_in;
        logic [31:0] now_ticks;
    } t_req;

    // response word
    typedef struct packed {
        logic [4:0] slot_out;
        logic       hit;
        logic       needs_read;
        t_status    status;
    } t_rsp;

    // one slot of the tag store
    typedef struct packed {
        logic [7:0]         device;
        logic [31:0]        block;
        logic               assigned;
        logic [COUNT_W-1:0] count;
        logic [31:0]        last_use;
        logic               contents_valid;
    } t_row;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic rd_slot;
        logic commit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic hit_found;
        logic scan_last;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: hdl/rlbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rlbc_ctrl
// Sequencer of the buffer cache: accepts a command, runs the slot scan or
// the single slot read, then has the datapath commit and report the word.
// ============================================================================
module rlbc_ctrl
    import rlbc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_cmd    i_cmd,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SLOT,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_cmd == CMD_READ) ? S_SCAN : S_SLOT;
                end
            end
            S_SCAN: begin
                if (i_sts.hit_found) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_SLOT: begin
                o_cmd.rd_slot = 1'b1;
                n_state       = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

// File: hdl/rlbc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rlbc_datapath
// Slot memory with per-slot valid bits, the pipelined tag match and oldest
// free slot search, the count update and the response register.
// ============================================================================
module rlbc_datapath
    import rlbc_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_req    i_req,
    input  wire t_dp_cmd i_cmd,
    output t_dp_sts      o_sts,
    output logic         o_valid,
    output t_rsp         o_rsp
);

    localparam int SW = $clog2(SLOTS);
    localparam int XW = (SW > SLOT_W) ? SW : SLOT_W;
    localparam logic [SW+4:0] SlotLim = (SW+5)'(SLOTS);
    localparam logic [SW-1:0] LastIdx = SW'(SLOTS - 1);

    // slot index to the 5-bit response field
    function automatic logic [SLOT_W-1:0] f_out_slot(input logic [SW-1:0] idx);
        logic [XW-1:0] wide;
        wide = XW'(idx);
        return wide[SLOT_W-1:0];
    endfunction

    // storage
    t_row             r_mem [SLOTS];
    logic [SLOTS-1:0] r_vld;

    // request and scan state
    t_req          r_req;
    logic [SW-1:0] r_scan_idx;
    logic          r_cmp_vld;
    logic [SW-1:0] r_cmp_idx;
    t_row          r_rd_data;
    logic          r_rd_ok;

    logic          r_hit_f;
    logic [SW-1:0] r_hit_idx;
    t_row          r_hit_row;
    logic          r_free_f;
    logic [SW-1:0] r_best_idx;
    logic [31:0]   r_best_lu;

    t_rsp r_rsp;
    logic r_valid;

    logic [SW+4:0] slot_ext;
    logic [SW-1:0] slot_addr;
    logic          slot_oor;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    t_row          row_rd;
    logic          is_match;
    logic          is_free;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    t_row          wr_row;
    t_rsp          rsp;

    // named slot decode
    assign slot_ext  = (SW+5)'(r_req.slot_in);
    assign slot_addr = slot_ext[SW-1:0];
    assign slot_oor  = (slot_ext >= SlotLim);

    // read port address
    assign rd_en   = i_cmd.scan | i_cmd.rd_slot;
    assign rd_addr = i_cmd.scan ? r_scan_idx : slot_addr;

    // never written slots read as zero
    assign row_rd = r_rd_ok ? r_rd_data : '0;

    // per-slot compare of the scanned row
    assign is_match = row_rd.assigned && (row_rd.device == r_req.device)
                      && (row_rd.block == r_req.block_number);
    assign is_free  = (row_rd.count == '0)
                      && (!r_free_f || (row_rd.last_use < r_best_lu));

    // commit: update row and form the response word
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_addr;
        wr_row  = row_rd;
        rsp     = '0;
        if (r_req.cmd == CMD_READ) begin
            if (r_hit_f) begin
                wr_en                 = 1'b1;
                wr_addr               = r_hit_idx;
                wr_row                = r_hit_row;
                wr_row.contents_valid = 1'b1;
                rsp.slot_out          = f_out_slot(r_hit_idx);
                rsp.hit               = 1'b1;
                rsp.needs_read        = !r_hit_row.contents_valid;
                if (r_hit_row.count == COUNT_MAX) begin
                    rsp.status = ST_COUNT;
                end else begin
                    wr_row.count = r_hit_row.count + COUNT_W'(1);
                end
            end else if (r_free_f) begin
                wr_en                 = 1'b1;
                wr_addr               = r_best_idx;
                wr_row.device         = r_req.device;
                wr_row.block          = r_req.block_number;
                wr_row.assigned       = 1'b1;
                wr_row.count          = COUNT_W'(1);
                wr_row.last_use       = r_req.now_ticks;
                wr_row.contents_valid = 1'b1;
                rsp.slot_out          = f_out_slot(r_best_idx);
                rsp.needs_read        = 1'b1;
            end else begin
                rsp.status = ST_NOFREE;
            end
        end else begin
            rsp.slot_out = r_req.slot_in;
            if (!slot_oor) begin
                case (r_req.cmd)
                    CMD_PIN: begin
                        if (row_rd.count == COUNT_MAX) begin
                            rsp.status = ST_COUNT;
                        end else begin
                            wr_en        = 1'b1;
                            wr_row.count = row_rd.count + COUNT_W'(1);
                        end
                    end
                    CMD_RELEASE, CMD_UNPIN: begin
                        if (row_rd.count == '0) begin
                            rsp.status = ST_COUNT;
                        end else begin
                            wr_en        = 1'b1;
                            wr_row.count = row_rd.count - COUNT_W'(1);
                            if (r_req.cmd == CMD_RELEASE
                                && row_rd.count == COUNT_W'(1)) begin
                                wr_row.last_use = r_req.now_ticks;
                            end
                        end
                    end
                    default: begin
                        wr_en = 1'b0;
                    end
                endcase
            end
        end
    end

    // slot memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.commit && wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
    end

    // valid bits, scan control and response strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_ok    <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_scan_idx <= '0;
            r_hit_f    <= 1'b0;
            r_free_f   <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            r_valid   <= i_cmd.commit;
            if (rd_en) begin
                r_rd_ok <= r_vld[rd_addr];
            end
            if (i_cmd.commit && wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.load) begin
                r_scan_idx <= '0;
                r_hit_f    <= 1'b0;
                r_free_f   <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_scan_idx <= r_scan_idx + SW'(1);
                end
                if (r_cmp_vld && !r_hit_f && is_match) begin
                    r_hit_f <= 1'b1;
                end
                if (r_cmp_vld && is_free) begin
                    r_free_f <= 1'b1;
                end
            end
        end
    end

    // request latch, search results and response word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_scan_idx;
        end
        if (r_cmp_vld && !r_hit_f && is_match) begin
            r_hit_idx <= r_cmp_idx;
            r_hit_row <= row_rd;
        end
        if (r_cmp_vld && is_free) begin
            r_best_idx <= r_cmp_idx;
            r_best_lu  <= row_rd.last_use;
        end
        if (i_cmd.commit) begin
            r_rsp <= rsp;
        end
    end

    assign o_sts.hit_found = r_hit_f;
    assign o_sts.scan_last = (r_scan_idx == LastIdx);
    assign o_valid         = r_valid;
    assign o_rsp           = r_rsp;

endmodule
`default_nettype wire

// File: hdl/refcounted_lru_block_buffer_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// refcounted_lru_block_buffer_cache
// Fully associative tag store of disk block buffers with reference counts
// and least recently used replacement of unreferenced slots.
// ============================================================================
// A command word is taken when start is high and busy is low. A read request
// scans the slot memory one slot per cycle through its single read port,
// stopping early on a hit. Release, pin and unpin read the named slot once.
// The response word shows on o_rsp with o_valid for exactly one cycle, the
// cycle busy drops, and must be taken then since the block cannot be stalled;
// a new command may be issued in that same cycle. Slots come out of reset
// empty with no clearing pass.
module refcounted_lru_block_buffer_cache
    import rlbc_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer
    rlbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_req.cmd),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // slot store and search
    rlbc_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

// File: hdl/rlbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rlbc_checker
// Port level checks of the buffer cache: command/response sequencing and
// the no free buffer response word.
// ============================================================================
module rlbc_checker
    import rlbc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire t_rsp o_rsp
);

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // response shows only once the block is free again
    a_rsp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("response while busy");

    // busy ends exactly with a response
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a response");

    // one response per word, never in back to back cycles
    a_single_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("response strobe held");

    // no free buffer carries an empty word
    a_nofree_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == ST_NOFREE)
        |-> !o_rsp.hit && !o_rsp.needs_read && (o_rsp.slot_out == '0))
        else $error("no free buffer response not cleared");

endmodule

bind refcounted_lru_block_buffer_cache rlbc_checker u_rlbc_checker (.*);
`default_nettype wire
